// File: hdl/rmrg_pkg.sv
// Shared constants, ALU op codes and rotate helper for the rotate-mix random generator.
package rmrg_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned AmtW  = 5;
  localparam int unsigned RndW  = 6;

  localparam logic [WordW-1:0] SubConst = 32'h3501_4541;
  localparam logic [WordW-1:0] AddConst = 32'h2152_4110;

  typedef enum logic [0:0] {
    FUNC_RESEED = 1'b0,
    FUNC_DRAW   = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_XOR
  } alu_op_e;

  // Right rotate; an amount of zero leaves the word as is.
  function automatic logic [WordW-1:0] rotr(input logic [WordW-1:0] v,
                                            input logic [AmtW-1:0]  n);
    logic [2*WordW-1:0] w;
    w = {v, v} >> n;
    return w[WordW-1:0];
  endfunction

endpackage

// File: hdl/rotate_mix_random_generator_unit.sv
// Top level of the rotate-mix random generator: sequencer, shared rotate/ALU unit, seed.
// Draw: runs 32 + time_now[4:0] mixing rounds (32 to 63) before the result is valid;
//   each mixing round takes four passes through one rotator and one ALU.
// Reseed: loads the inverted time as seed, no result. One word is in work at a time; the next word is taken
//   the cycle after the result loads, even while that result still waits at the output.
// Reset: asynchronous, active low; seed clears to zero, no result pending.
module rotate_mix_random_generator_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        func_i,
  input  logic [31:0] time_now_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] random_word_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    PH_A,
    PH_B,
    PH_C,
    PH_D
  } phase_e;

  state_e state_q;
  phase_e phase_q;
  logic [rmrg_pkg::RndW-1:0]  rnd_left_q;
  logic [rmrg_pkg::WordW-1:0] seed_q, seed_d;
  logic [rmrg_pkg::WordW-1:0] ns_q, ns_d;
  logic                       out_valid_q;
  logic [rmrg_pkg::WordW-1:0] out_word_q;

  logic [rmrg_pkg::WordW-1:0] rot_src, rot_res;
  logic [rmrg_pkg::AmtW-1:0]  rot_amt;
  logic [rmrg_pkg::WordW-1:0] alu_a, alu_b, alu_res;
  rmrg_pkg::alu_op_e          alu_op;

  logic in_acc;
  logic out_free;

  assign in_stall_o    = (state_q != ST_IDLE);
  assign in_acc        = in_valid_i && !in_stall_o;
  assign out_free      = !out_valid_q || !out_stall_i;
  assign out_valid_o   = out_valid_q;
  assign random_word_o = out_word_q;

  // Operand select for the shared rotator and ALU, one quarter round per cycle.
  always_comb begin
    rot_src = ns_q;
    rot_amt = seed_q[4:0];
    case (phase_q)
      PH_A: begin
        rot_src = ns_q;
        rot_amt = seed_q[4:0];
      end
      PH_B: begin
        rot_src = ns_q;
        rot_amt = seed_q[31:27];
      end
      PH_C: begin
        rot_src = seed_q;
        rot_amt = ns_q[9:5];
      end
      PH_D: begin
        rot_src = ns_q;
        rot_amt = seed_q[17:13];
      end
      default: begin
        rot_src = ns_q;
        rot_amt = seed_q[4:0];
      end
    endcase
  end

  assign rot_res = rmrg_pkg::rotr(rot_src, rot_amt);

  always_comb begin
    alu_a  = seed_q;
    alu_b  = rmrg_pkg::AddConst;
    alu_op = rmrg_pkg::ALU_ADD;
    case (phase_q)
      PH_A: begin
        alu_a  = seed_q;
        alu_b  = rot_res[0] ? rmrg_pkg::SubConst : rmrg_pkg::AddConst;
        alu_op = rot_res[0] ? rmrg_pkg::ALU_SUB : rmrg_pkg::ALU_ADD;
      end
      PH_B: begin
        alu_a  = rot_res;
        alu_b  = seed_q;
        alu_op = seed_q[1] ? rmrg_pkg::ALU_XOR : rmrg_pkg::ALU_SUB;
      end
      PH_C: begin
        alu_a  = rot_res;
        alu_b  = ns_q;
        alu_op = ns_q[2] ? rmrg_pkg::ALU_ADD : rmrg_pkg::ALU_XOR;
      end
      PH_D: begin
        alu_a  = seed_q[3] ? rot_res : seed_q;
        alu_b  = seed_q[3] ? seed_q : rot_res;
        alu_op = seed_q[3] ? rmrg_pkg::ALU_ADD : rmrg_pkg::ALU_SUB;
      end
      default: begin
        alu_a  = seed_q;
        alu_b  = rmrg_pkg::AddConst;
        alu_op = rmrg_pkg::ALU_ADD;
      end
    endcase
  end

  always_comb begin
    case (alu_op)
      rmrg_pkg::ALU_ADD: alu_res = alu_a + alu_b;
      rmrg_pkg::ALU_SUB: alu_res = alu_a - alu_b;
      rmrg_pkg::ALU_XOR: alu_res = alu_a ^ alu_b;
      default:           alu_res = alu_a;
    endcase
  end

  // Write back the quarter-round result.
  always_comb begin
    ns_d   = ns_q;
    seed_d = seed_q;
    case (phase_q)
      PH_A: begin
        ns_d   = rot_res;
        seed_d = alu_res;
      end
      PH_B: ns_d = alu_res;
      PH_C: seed_d = alu_res;
      PH_D: begin
        if (seed_q[3]) begin
          ns_d = alu_res;
        end else begin
          ns_d   = rot_res;
          seed_d = alu_res;
        end
      end
      default: begin
        ns_d   = ns_q;
        seed_d = seed_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_A;
      rnd_left_q  <= '0;
      seed_q      <= '0;
      ns_q        <= '0;
      out_valid_q <= 1'b0;
      out_word_q  <= '0;
    end else begin
      // Load a finished word, else drop the one just taken.
      if ((state_q == ST_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            if (func_i == rmrg_pkg::FUNC_RESEED) begin
              seed_q <= ~time_now_i;
            end else begin
              ns_q       <= time_now_i;
              rnd_left_q <= {1'b1, time_now_i[4:0]};
              phase_q    <= PH_A;
              state_q    <= ST_RUN;
            end
          end
        end
        ST_RUN: begin
          ns_q   <= ns_d;
          seed_q <= seed_d;
          case (phase_q)
            PH_A: phase_q <= PH_B;
            PH_B: phase_q <= PH_C;
            PH_C: phase_q <= PH_D;
            PH_D: begin
              phase_q    <= PH_A;
              rnd_left_q <= rnd_left_q - {{(rmrg_pkg::RndW-1){1'b0}}, 1'b1};
              if (rnd_left_q == {{(rmrg_pkg::RndW-1){1'b0}}, 1'b1}) begin
                state_q <= ST_DONE;
              end
            end
            default: phase_q <= PH_A;
          endcase
        end
        ST_DONE: begin
          // Hold until the output register is free.
          if (out_free) begin
            out_word_q <= ns_q;
            state_q    <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  a_run_has_rounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (rnd_left_q != '0))
    else $error("round counter empty while running");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_DONE))
    else $error("result raised outside finish state");

  a_reseed_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (func_i == rmrg_pkg::FUNC_RESEED))
      |=> (seed_q == ~$past(time_now_i)) && (state_q == ST_IDLE))
    else $error("reseed did not load inverted time");

  a_phase_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) && (phase_q == PH_D) && (rnd_left_q != 6'd1)
      |=> (state_q == ST_RUN) && (phase_q == PH_A))
    else $error("round sequencer lost its place");

endmodule
